/* design/dtt_pkg.sv */
// ----------------------------------------------------------------------------
// dtt_pkg
// Shared types and constants for the deadline timer table.
// ----------------------------------------------------------------------------
`default_nettype none

package dtt_pkg;

  localparam int unsigned CNT_W  = 32;
  localparam int unsigned JOB_W  = 32;
  localparam int unsigned IN_IDX_W = 7;
  localparam int unsigned HOUR_W = 5;
  localparam int unsigned MIN_W  = 6;
  localparam int unsigned SEC_W  = 6;

  localparam logic [SEC_W-1:0]  SEC_LAST  = SEC_W'(59);
  localparam logic [MIN_W-1:0]  MIN_LAST  = MIN_W'(59);
  localparam logic [HOUR_W-1:0] HOUR_LAST = HOUR_W'(23);

  // job code that drives the time-of-day clock
  localparam logic [JOB_W-1:0] JOB_CLOCK = '0;

  localparam logic ACT_TICK = 1'b0;
  localparam logic ACT_ARM  = 1'b1;

  typedef struct packed {
    logic             active;
    logic [CNT_W-1:0] deadline;
    logic [JOB_W-1:0] job;
  } entry_t;

  typedef struct packed {
    logic en;
    logic we;
  } mem_ctl_t;

  typedef struct packed {
    logic start;   // clear running minimum
    logic sample;  // read data of a scan access is valid
  } scan_ctl_t;

endpackage

`default_nettype wire

/* design/dtt_mem.sv */
// ----------------------------------------------------------------------------
// dtt_mem
// Single-port slot table, one access per cycle, registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module dtt_mem #(
  parameter int unsigned SLOT_COUNT = 128,
  parameter int unsigned IDX_W      = 7
) (
  input  wire logic              clk,
  input  wire dtt_pkg::mem_ctl_t ctl,
  input  wire logic [IDX_W-1:0]  addr,
  input  wire dtt_pkg::entry_t   wdata,
  output dtt_pkg::entry_t        rdata
);

  dtt_pkg::entry_t mem [SLOT_COUNT];
  dtt_pkg::entry_t rdata_r;

  always_ff @(posedge clk) begin
    if (ctl.en) begin
      if (ctl.we) begin
        mem[addr] <= wdata;
      end else begin
        rdata_r <= mem[addr];
      end
    end
  end

  assign rdata = rdata_r;

endmodule

`default_nettype wire

/* design/dtt_scan.sv */
// ----------------------------------------------------------------------------
// dtt_scan
// Running minimum over the slot words streamed out of the table.
// ----------------------------------------------------------------------------
`default_nettype none

module dtt_scan #(
  parameter int unsigned IDX_W = 7
) (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire dtt_pkg::scan_ctl_t ctl,
  input  wire logic [IDX_W-1:0]   rd_idx,
  input  wire dtt_pkg::entry_t    rd_entry,
  output logic                    found,
  output logic [IDX_W-1:0]        best_idx
);

  logic                      found_r;
  logic [dtt_pkg::CNT_W-1:0] best_dl_r;
  logic [IDX_W-1:0]          best_idx_r;
  logic                      take;

  // strict less-than keeps the lowest index on ties
  assign take = ctl.sample && rd_entry.active &&
                (!found_r || (rd_entry.deadline < best_dl_r));

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      found_r <= 1'b0;
    end else if (ctl.start) begin
      found_r <= 1'b0;
    end else if (take) begin
      found_r <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      best_dl_r  <= rd_entry.deadline;
      best_idx_r <= rd_idx;
    end
  end

  assign found    = found_r;
  assign best_idx = best_idx_r;

endmodule

`default_nettype wire

/* design/dtt_tod.sv */
// ----------------------------------------------------------------------------
// dtt_tod
// Time-of-day clock: seconds, minutes, hours, wrapping at 24 hours.
// ----------------------------------------------------------------------------
`default_nettype none

module dtt_tod (
  input  wire logic                       clk,
  input  wire logic                       rst_n,
  input  wire logic                       advance,
  output logic [dtt_pkg::HOUR_W-1:0]      hours,
  output logic [dtt_pkg::MIN_W-1:0]       minutes,
  output logic [dtt_pkg::SEC_W-1:0]       seconds
);

  logic [dtt_pkg::HOUR_W-1:0] hours_r,   hours_nxt;
  logic [dtt_pkg::MIN_W-1:0]  minutes_r, minutes_nxt;
  logic [dtt_pkg::SEC_W-1:0]  seconds_r, seconds_nxt;

  always_comb begin
    hours_nxt   = hours_r;
    minutes_nxt = minutes_r;
    seconds_nxt = seconds_r;
    if (advance) begin
      if (seconds_r == dtt_pkg::SEC_LAST) begin
        seconds_nxt = '0;
        if (minutes_r == dtt_pkg::MIN_LAST) begin
          minutes_nxt = '0;
          if (hours_r == dtt_pkg::HOUR_LAST) begin
            hours_nxt = '0;
          end else begin
            hours_nxt = hours_r + 1'b1;
          end
        end else begin
          minutes_nxt = minutes_r + 1'b1;
        end
      end else begin
        seconds_nxt = seconds_r + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      hours_r   <= '0;
      minutes_r <= '0;
      seconds_r <= '0;
    end else begin
      hours_r   <= hours_nxt;
      minutes_r <= minutes_nxt;
      seconds_r <= seconds_nxt;
    end
  end

  assign hours   = hours_r;
  assign minutes = minutes_r;
  assign seconds = seconds_r;

endmodule

`default_nettype wire

/* design/deadline_timer_table_core.sv */
// ----------------------------------------------------------------------------
// deadline_timer_table_core
// Tick-driven timer table: arms slots, fires the selected slot on a tick that
// reaches its deadline and rescans the table for the earliest deadline.
// ----------------------------------------------------------------------------
//  channel | dir | handshake          | word
//  in_     | in  | in_valid/in_stall  | action, slot_index, deadline_count, job_code
//  out_    | out | out_valid/out_stall| fired, fired_job, hours, minutes, seconds
//
//  Tick that does not fire: the selected slot word is read on accept and
//  checked in TICK_CHK, then EMIT registers the result word; the next input
//  word can be taken once the block is back in IDLE. Arm of a valid slot,
//  tick that fires: the slot is written, then SCAN, SCAN_LAST, SEL and EMIT.
//  The scan reads one slot word per cycle through the table's single port.
//  After reset the table is cleared one slot per cycle, with in_stall high
//  until every slot is cleared.
//  A result held by out_stall does not block the next input word.
// ----------------------------------------------------------------------------
`default_nettype none

module deadline_timer_table_core #(
  parameter int unsigned SLOT_COUNT = 128
) (
  input  wire logic                           clk,
  input  wire logic                           rst_n,

  input  wire logic                           in_valid,
  output logic                                in_stall,
  input  wire logic                           in_action,
  input  wire logic [dtt_pkg::IN_IDX_W-1:0]   in_slot_index,
  input  wire logic [dtt_pkg::CNT_W-1:0]      in_deadline_count,
  input  wire logic [dtt_pkg::JOB_W-1:0]      in_job_code,

  output logic                                out_valid,
  input  wire logic                           out_stall,
  output logic                                out_fired,
  output logic [dtt_pkg::JOB_W-1:0]           out_fired_job,
  output logic [dtt_pkg::HOUR_W-1:0]          out_hours,
  output logic [dtt_pkg::MIN_W-1:0]           out_minutes,
  output logic [dtt_pkg::SEC_W-1:0]           out_seconds
);

  localparam int unsigned IDX_W = (SLOT_COUNT > 2) ? $clog2(SLOT_COUNT) : 1;
  localparam logic [IDX_W-1:0] IDX_LAST = IDX_W'(SLOT_COUNT - 1);

  localparam logic [2:0] ST_CLEAR     = 3'd0;
  localparam logic [2:0] ST_IDLE      = 3'd1;
  localparam logic [2:0] ST_TICK_CHK  = 3'd2;
  localparam logic [2:0] ST_SCAN      = 3'd3;
  localparam logic [2:0] ST_SCAN_LAST = 3'd4;
  localparam logic [2:0] ST_SEL       = 3'd5;
  localparam logic [2:0] ST_EMIT      = 3'd6;

  logic [2:0]                state_r, state_nxt;
  logic [IDX_W-1:0]          cnt_r, cnt_nxt;        // clear / scan address
  logic [IDX_W-1:0]          next_slot_r, next_slot_nxt;
  logic [dtt_pkg::CNT_W-1:0] tick_count_r, tick_count_nxt;
  logic                      sample_r;
  logic [IDX_W-1:0]          rd_idx_r;
  logic                      out_valid_r, out_valid_nxt;
  logic                      res_fired_r, res_fired_nxt;
  logic [dtt_pkg::JOB_W-1:0] res_job_r, res_job_nxt;
  logic                      out_fired_r;
  logic [dtt_pkg::JOB_W-1:0] out_job_r;
  logic [dtt_pkg::HOUR_W-1:0] out_hours_r;
  logic [dtt_pkg::MIN_W-1:0]  out_minutes_r;
  logic [dtt_pkg::SEC_W-1:0]  out_seconds_r;

  dtt_pkg::mem_ctl_t  mem_ctl;
  logic [IDX_W-1:0]   mem_addr;
  dtt_pkg::entry_t    mem_wdata;
  dtt_pkg::entry_t    mem_rdata;
  dtt_pkg::scan_ctl_t scan_ctl;
  logic               scan_found;
  logic [IDX_W-1:0]   scan_best;
  logic               tod_advance;
  logic [dtt_pkg::HOUR_W-1:0] tod_hours;
  logic [dtt_pkg::MIN_W-1:0]  tod_minutes;
  logic [dtt_pkg::SEC_W-1:0]  tod_seconds;

  logic in_acc;
  logic arm_ok;
  logic hit;
  logic out_free;

  assign in_stall = (state_r != ST_IDLE);
  assign in_acc   = in_valid && !in_stall;
  assign arm_ok   = (in_slot_index != '0) &&
                    ({25'd0, in_slot_index} < 32'(SLOT_COUNT));
  assign hit      = mem_rdata.active && (mem_rdata.deadline == tick_count_r);
  assign out_free = !out_valid_r || !out_stall;

  assign tod_advance = (state_r == ST_TICK_CHK) && hit &&
                       (mem_rdata.job == dtt_pkg::JOB_CLOCK);

  assign scan_ctl.start  = ((state_r == ST_IDLE) && in_acc &&
                            (in_action == dtt_pkg::ACT_ARM) && arm_ok) ||
                           ((state_r == ST_TICK_CHK) && hit);
  assign scan_ctl.sample = sample_r;

  // table access
  always_comb begin
    mem_ctl   = '0;
    mem_addr  = cnt_r;
    mem_wdata = '0;
    unique case (state_r)
      ST_CLEAR: begin
        mem_ctl = '{en: 1'b1, we: 1'b1};
      end
      ST_IDLE: begin
        if (in_acc) begin
          if (in_action == dtt_pkg::ACT_ARM) begin
            mem_ctl   = '{en: arm_ok, we: 1'b1};
            mem_addr  = IDX_W'(in_slot_index);
            mem_wdata = '{active: 1'b1, deadline: in_deadline_count, job: in_job_code};
          end else begin
            mem_ctl  = '{en: 1'b1, we: 1'b0};
            mem_addr = next_slot_r;
          end
        end
      end
      ST_TICK_CHK: begin
        mem_ctl   = '{en: hit, we: 1'b1};
        mem_addr  = next_slot_r;
        mem_wdata = '{active: 1'b0, deadline: mem_rdata.deadline, job: mem_rdata.job};
      end
      ST_SCAN: begin
        mem_ctl = '{en: 1'b1, we: 1'b0};
      end
      ST_SCAN_LAST, ST_SEL, ST_EMIT: begin
        mem_ctl = '0;
      end
      default: begin
        mem_ctl = '0;
      end
    endcase
  end

  // sequencer
  always_comb begin
    state_nxt      = state_r;
    cnt_nxt        = cnt_r;
    next_slot_nxt  = next_slot_r;
    tick_count_nxt = tick_count_r;
    res_fired_nxt  = res_fired_r;
    res_job_nxt    = res_job_r;
    unique case (state_r)
      ST_CLEAR: begin
        cnt_nxt = cnt_r + 1'b1;
        if (cnt_r == IDX_LAST) begin
          state_nxt = ST_IDLE;
        end
      end
      ST_IDLE: begin
        cnt_nxt = IDX_W'(1);
        if (in_acc) begin
          res_fired_nxt = 1'b0;
          res_job_nxt   = '0;
          if (in_action == dtt_pkg::ACT_ARM) begin
            state_nxt = arm_ok ? ST_SCAN : ST_EMIT;
          end else begin
            tick_count_nxt = tick_count_r + 1'b1;
            state_nxt      = ST_TICK_CHK;
          end
        end
      end
      ST_TICK_CHK: begin
        if (hit) begin
          res_fired_nxt = 1'b1;
          res_job_nxt   = mem_rdata.job;
          state_nxt     = ST_SCAN;
        end else begin
          state_nxt = ST_EMIT;
        end
      end
      ST_SCAN: begin
        cnt_nxt = cnt_r + 1'b1;
        if (cnt_r == IDX_LAST) begin
          state_nxt = ST_SCAN_LAST;
        end
      end
      ST_SCAN_LAST: begin
        state_nxt = ST_SEL;
      end
      ST_SEL: begin
        // no active slot left: selection stays
        if (scan_found) begin
          next_slot_nxt = scan_best;
        end
        state_nxt = ST_EMIT;
      end
      ST_EMIT: begin
        if (out_free) begin
          state_nxt = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_comb begin
    out_valid_nxt = out_valid_r && out_stall;
    if ((state_r == ST_EMIT) && out_free) begin
      out_valid_nxt = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= ST_CLEAR;
      cnt_r        <= '0;
      next_slot_r  <= '0;
      tick_count_r <= '0;
      sample_r     <= 1'b0;
      out_valid_r  <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      cnt_r        <= cnt_nxt;
      next_slot_r  <= next_slot_nxt;
      tick_count_r <= tick_count_nxt;
      sample_r     <= (state_r == ST_SCAN);
      out_valid_r  <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    rd_idx_r    <= cnt_r;
    res_fired_r <= res_fired_nxt;
    res_job_r   <= res_job_nxt;
    if ((state_r == ST_EMIT) && out_free) begin
      out_fired_r   <= res_fired_r;
      out_job_r     <= res_job_r;
      out_hours_r   <= tod_hours;
      out_minutes_r <= tod_minutes;
      out_seconds_r <= tod_seconds;
    end
  end

  dtt_mem #(
    .SLOT_COUNT (SLOT_COUNT),
    .IDX_W      (IDX_W)
  ) u_mem (
    .clk   (clk),
    .ctl   (mem_ctl),
    .addr  (mem_addr),
    .wdata (mem_wdata),
    .rdata (mem_rdata)
  );

  dtt_scan #(
    .IDX_W (IDX_W)
  ) u_scan (
    .clk      (clk),
    .rst_n    (rst_n),
    .ctl      (scan_ctl),
    .rd_idx   (rd_idx_r),
    .rd_entry (mem_rdata),
    .found    (scan_found),
    .best_idx (scan_best)
  );

  dtt_tod u_tod (
    .clk     (clk),
    .rst_n   (rst_n),
    .advance (tod_advance),
    .hours   (tod_hours),
    .minutes (tod_minutes),
    .seconds (tod_seconds)
  );

  assign out_valid     = out_valid_r;
  assign out_fired     = out_fired_r;
  assign out_fired_job = out_job_r;
  assign out_hours     = out_hours_r;
  assign out_minutes   = out_minutes_r;
  assign out_seconds   = out_seconds_r;

endmodule

`default_nettype wire

/* design/dtt_checker.sv */
// ----------------------------------------------------------------------------
// dtt_checker
// Port-level checks of the deadline timer table, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

module dtt_checker (
  input wire logic                           clk,
  input wire logic                           rst_n,
  input wire logic                           in_valid,
  input wire logic                           in_stall,
  input wire logic                           out_valid,
  input wire logic                           out_stall,
  input wire logic                           out_fired,
  input wire logic [dtt_pkg::JOB_W-1:0]      out_fired_job,
  input wire logic [dtt_pkg::HOUR_W-1:0]     out_hours,
  input wire logic [dtt_pkg::MIN_W-1:0]      out_minutes,
  input wire logic [dtt_pkg::SEC_W-1:0]      out_seconds
);

  logic [1:0] pend_r;
  logic       in_acc;
  logic       out_acc;

  assign in_acc  = in_valid && !in_stall;
  assign out_acc = out_valid && !out_stall;

  // words accepted but not yet delivered
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pend_r <= '0;
    end else begin
      pend_r <= pend_r + {1'b0, in_acc} - {1'b0, out_acc};
    end
  end

  a_no_spurious_out: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (pend_r != 2'd0))
    else $error("result word without an accepted input word");

  a_pend_bound: assert property (@(posedge clk) disable iff (!rst_n)
    pend_r != 2'd3)
    else $error("more than two words outstanding");

  a_job_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_fired) |-> (out_fired_job == '0))
    else $error("job code reported without a fire");

  a_clock_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> ((out_seconds <= dtt_pkg::SEC_LAST) &&
                   (out_minutes <= dtt_pkg::MIN_LAST) &&
                   (out_hours <= dtt_pkg::HOUR_LAST)))
    else $error("time of day out of range");

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_stall) |=> (out_valid && $stable(out_fired) &&
                                  $stable(out_fired_job) && $stable(out_seconds)))
    else $error("stalled result word changed");

endmodule

bind deadline_timer_table_core dtt_checker u_dtt_checker (.*);

`default_nettype wire

/* tb/tb.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for deadline_timer_table_core. A plan model shapes the
// stimulus (arms near the current tick count, repairs of stale deadlines);
// a second copy of the same model predicts every result word at accept time.
// ----------------------------------------------------------------------------

module tb;

  localparam int unsigned SLOT_COUNT = 128;
  localparam int unsigned RAND_WORDS = 1600;
  localparam int unsigned IDLE_LIMIT = 4000;
  localparam int unsigned MAX_REPORT = 10;

  // two copies of the timer state: one steers stimulus, one predicts results
  localparam int PLAN = 0;
  localparam int PRED = 1;

  typedef struct packed {
    logic                         action;
    logic [dtt_pkg::IN_IDX_W-1:0] slot;
    logic [dtt_pkg::CNT_W-1:0]    due;
    logic [dtt_pkg::JOB_W-1:0]    code;
  } timer_word_t;

  typedef struct packed {
    logic                       fired;
    logic [dtt_pkg::JOB_W-1:0]  job;
    logic [dtt_pkg::HOUR_W-1:0] hrs;
    logic [dtt_pkg::MIN_W-1:0]  mins;
    logic [dtt_pkg::SEC_W-1:0]  secs;
  } timer_result_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;

  logic                         in_valid = 1'b0;
  logic                         in_stall;
  logic                         in_action = dtt_pkg::ACT_TICK;
  logic [dtt_pkg::IN_IDX_W-1:0] in_slot_index = '0;
  logic [dtt_pkg::CNT_W-1:0]    in_deadline_count = '0;
  logic [dtt_pkg::JOB_W-1:0]    in_job_code = '0;

  logic                       out_valid;
  logic                       out_stall = 1'b0;
  logic                       out_fired;
  logic [dtt_pkg::JOB_W-1:0]  out_fired_job;
  logic [dtt_pkg::HOUR_W-1:0] out_hours;
  logic [dtt_pkg::MIN_W-1:0]  out_minutes;
  logic [dtt_pkg::SEC_W-1:0]  out_seconds;

  deadline_timer_table_core #(
    .SLOT_COUNT (SLOT_COUNT)
  ) DUT (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_valid          (in_valid),
    .in_stall          (in_stall),
    .in_action         (in_action),
    .in_slot_index     (in_slot_index),
    .in_deadline_count (in_deadline_count),
    .in_job_code       (in_job_code),
    .out_valid         (out_valid),
    .out_stall         (out_stall),
    .out_fired         (out_fired),
    .out_fired_job     (out_fired_job),
    .out_hours         (out_hours),
    .out_minutes       (out_minutes),
    .out_seconds       (out_seconds)
  );

  always #10 clk = ~clk;

  // --------------------------------------------------------------------------
  // timer table model, two instances
  // --------------------------------------------------------------------------
  logic [dtt_pkg::CNT_W-1:0]  tick_cnt  [2];
  bit                         slot_live [2][SLOT_COUNT];
  logic [dtt_pkg::CNT_W-1:0]  slot_due  [2][SLOT_COUNT];
  logic [dtt_pkg::JOB_W-1:0]  slot_code [2][SLOT_COUNT];
  int unsigned                sel_slot  [2];
  logic [dtt_pkg::HOUR_W-1:0] tod_h     [2];
  logic [dtt_pkg::MIN_W-1:0]  tod_m     [2];
  logic [dtt_pkg::SEC_W-1:0]  tod_s     [2];

  task automatic pick_earliest(input int m);
    bit                        found;
    logic [dtt_pkg::CNT_W-1:0] best;
    found = 1'b0;
    best = '0;
    // strict less-than keeps the lowest index on a tie
    for (int i = 1; i < SLOT_COUNT; i++) begin
      if (slot_live[m][i] && (!found || slot_due[m][i] < best)) begin
        found = 1'b1;
        best = slot_due[m][i];
        sel_slot[m] = i;
      end
    end
  endtask

  task automatic timer_step(input int m, input timer_word_t w, output timer_result_t r);
    int unsigned s;
    r = '0;
    if (w.action == dtt_pkg::ACT_ARM) begin
      if (w.slot != 0 && w.slot < SLOT_COUNT) begin
        slot_due[m][w.slot] = w.due;
        slot_code[m][w.slot] = w.code;
        slot_live[m][w.slot] = 1'b1;
        pick_earliest(m);
      end
    end else begin
      s = sel_slot[m];
      tick_cnt[m] = tick_cnt[m] + 1'b1;
      if (s < SLOT_COUNT && slot_live[m][s] && slot_due[m][s] == tick_cnt[m]) begin
        r.fired = 1'b1;
        r.job = slot_code[m][s];
        if (r.job == dtt_pkg::JOB_CLOCK) begin
          if (tod_s[m] == dtt_pkg::SEC_LAST) begin
            tod_s[m] = '0;
            if (tod_m[m] == dtt_pkg::MIN_LAST) begin
              tod_m[m] = '0;
              tod_h[m] = (tod_h[m] == dtt_pkg::HOUR_LAST) ? '0 : tod_h[m] + 1'b1;
            end else begin
              tod_m[m] = tod_m[m] + 1'b1;
            end
          end else begin
            tod_s[m] = tod_s[m] + 1'b1;
          end
        end
        slot_live[m][s] = 1'b0;
        pick_earliest(m);
      end
    end
    r.hrs = tod_h[m];
    r.mins = tod_m[m];
    r.secs = tod_s[m];
  endtask

  // --------------------------------------------------------------------------
  // stimulus plan
  // --------------------------------------------------------------------------
  timer_word_t   pending_q[$];
  timer_result_t expect_q[$];
  int unsigned   planned_cnt = 0;
  int unsigned   accepted_cnt = 0;
  int unsigned   fail_cnt = 0;

  task automatic plan_word(input logic act, input int unsigned idx,
                           input logic [dtt_pkg::CNT_W-1:0] due,
                           input logic [dtt_pkg::JOB_W-1:0] code);
    timer_word_t   w;
    timer_result_t r;
    w.action = act;
    w.slot = idx[dtt_pkg::IN_IDX_W-1:0];
    w.due = due;
    w.code = code;
    timer_step(PLAN, w, r);
    pending_q.push_back(w);
    planned_cnt++;
  endtask

  function automatic logic [dtt_pkg::JOB_W-1:0] rand_code();
    return ($urandom_range(0, 1) != 0) ? dtt_pkg::JOB_W'($urandom) : dtt_pkg::JOB_CLOCK;
  endfunction

  initial begin
    int unsigned s;
    int unsigned pick;
    for (int m = 0; m < 2; m++) begin
      tick_cnt[m] = '0;
      sel_slot[m] = 0;
      tod_h[m] = '0;
      tod_m[m] = '0;
      tod_s[m] = '0;
      for (int i = 0; i < SLOT_COUNT; i++) begin
        slot_live[m][i] = 1'b0;
        slot_due[m][i] = '0;
        slot_code[m][i] = '0;
      end
    end

    // directed: idle tick, ignored arm of slot zero, extreme slot and codes
    plan_word(dtt_pkg::ACT_TICK, 0, '0, '0);
    plan_word(dtt_pkg::ACT_ARM, 0, 32'd5, 32'd7);
    plan_word(dtt_pkg::ACT_ARM, SLOT_COUNT - 1, tick_cnt[PLAN] + 1, '1);
    plan_word(dtt_pkg::ACT_TICK, 0, '1, '1);
    // largest deadline: compared unsigned, never wins while others wait
    plan_word(dtt_pkg::ACT_ARM, 1, '1, 32'hA5A5_A5A5);
    // equal deadlines: lower index fires, the other goes stale
    plan_word(dtt_pkg::ACT_ARM, 9, tick_cnt[PLAN] + 2, dtt_pkg::JOB_CLOCK);
    plan_word(dtt_pkg::ACT_ARM, 3, tick_cnt[PLAN] + 2, 32'd1);
    plan_word(dtt_pkg::ACT_TICK, 0, '0, '0);
    plan_word(dtt_pkg::ACT_TICK, 0, '0, '0);
    plan_word(dtt_pkg::ACT_TICK, 0, '0, '0);
    plan_word(dtt_pkg::ACT_ARM, 9, tick_cnt[PLAN] + 1, dtt_pkg::JOB_CLOCK);
    plan_word(dtt_pkg::ACT_TICK, 0, '0, '0);
    // deadline already passed holds the selection and blocks slot 21
    plan_word(dtt_pkg::ACT_ARM, 20, '0, 32'd2);
    plan_word(dtt_pkg::ACT_ARM, 21, tick_cnt[PLAN] + 1, 32'd3);
    plan_word(dtt_pkg::ACT_TICK, 0, '0, '0);
    plan_word(dtt_pkg::ACT_ARM, 21, tick_cnt[PLAN] + 2, 32'd3);
    plan_word(dtt_pkg::ACT_ARM, 20, tick_cnt[PLAN] + 1, 32'd2);
    plan_word(dtt_pkg::ACT_TICK, 0, '0, '0);
    plan_word(dtt_pkg::ACT_TICK, 0, '0, '0);
    // overwrite of a slot that is still live
    plan_word(dtt_pkg::ACT_ARM, 64, 32'h8000_0000, 32'h8000_0000);
    plan_word(dtt_pkg::ACT_ARM, 64, tick_cnt[PLAN] + 1, dtt_pkg::JOB_CLOCK);
    plan_word(dtt_pkg::ACT_TICK, 0, '0, '0);

    for (int n = 0; n < RAND_WORDS; n++) begin
      s = sel_slot[PLAN];
      // mostly repair a stale selection so later slots keep firing
      if (slot_live[PLAN][s] && slot_due[PLAN][s] <= tick_cnt[PLAN] &&
          $urandom_range(0, 9) != 0) begin
        plan_word(dtt_pkg::ACT_ARM, s, tick_cnt[PLAN] + $urandom_range(1, 4), rand_code());
      end else begin
        pick = $urandom_range(0, 99);
        if (pick < 55)
          plan_word(dtt_pkg::ACT_TICK, $urandom_range(0, 127), $urandom, $urandom);
        else if (pick < 93)
          plan_word(dtt_pkg::ACT_ARM, $urandom_range(1, SLOT_COUNT - 1),
                    tick_cnt[PLAN] + $urandom_range(1, 6), rand_code());
        else if (pick < 96)
          plan_word(dtt_pkg::ACT_ARM, 0, $urandom, $urandom);
        else
          plan_word(dtt_pkg::ACT_ARM, $urandom_range(1, SLOT_COUNT - 1),
                    $urandom, $urandom);
      end
    end

    repeat (12) @(posedge clk);
    rst_n <= 1'b1;

    while (accepted_cnt != planned_cnt || expect_q.size() != 0) @(negedge clk);
    repeat (SLOT_COUNT + 32) @(posedge clk);
    if (fail_cnt == 0)
      $display("** deadline_timer_table_core: PASSED **");
    else
      $display("** deadline_timer_table_core: FAILED **");
    $finish;
  end

  // --------------------------------------------------------------------------
  // driver
  // --------------------------------------------------------------------------
  timer_word_t   cur_word;
  timer_result_t pred_res;
  bit            in_take;
  bit            in_load;
  bit            in_burst = 1'b0;
  int unsigned   in_gap = 0;

  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else begin
      in_take = in_valid && !in_stall;
      if (in_take) begin
        timer_step(PRED, cur_word, pred_res);
        expect_q.push_back(pred_res);
        accepted_cnt++;
        if ($urandom_range(0, 149) == 0) in_burst = !in_burst;
        in_gap = in_burst ? 0 : $urandom_range(0, 7);
      end
      in_load = 1'b0;
      if (!in_valid || in_take) begin
        if (in_gap != 0)
          in_gap--;
        else if (pending_q.size() != 0)
          in_load = 1'b1;
      end
      if (in_load) begin
        cur_word = pending_q.pop_front();
        in_valid <= 1'b1;
        in_action <= cur_word.action;
        in_slot_index <= cur_word.slot;
        in_deadline_count <= cur_word.due;
        in_job_code <= cur_word.code;
      end else if (in_take) begin
        in_valid <= 1'b0;
      end
    end
  end

  // --------------------------------------------------------------------------
  // monitor and checker
  // --------------------------------------------------------------------------
  timer_result_t got_res;
  timer_result_t want_res;
  bit            out_burst = 1'b0;
  int unsigned   out_wait = 0;

  task automatic note_failure(input timer_result_t want, input timer_result_t got,
                              input bit orphan);
    fail_cnt++;
    if (fail_cnt <= MAX_REPORT) begin
      if (orphan)
        $display("%0t: result word with nothing expected: fired=%0d job=%h %0d:%0d:%0d",
                 $realtime, got.fired, got.job, got.hrs, got.mins, got.secs);
      else
        $display("%0t: mismatch exp fired=%0d job=%h %0d:%0d:%0d got %0d %h %0d:%0d:%0d",
                 $realtime, want.fired, want.job, want.hrs, want.mins, want.secs,
                 got.fired, got.job, got.hrs, got.mins, got.secs);
    end
  endtask

  always @(posedge clk) begin
    if (!rst_n) begin
      out_stall <= 1'b0;
    end else begin
      if (out_valid && !out_stall) begin
        got_res = {out_fired, out_fired_job, out_hours, out_minutes, out_seconds};
        if (expect_q.size() == 0) begin
          note_failure('0, got_res, 1'b1);
        end else begin
          want_res = expect_q.pop_front();
          if (got_res.fired !== want_res.fired || got_res.job !== want_res.job ||
              got_res.hrs !== want_res.hrs || got_res.mins !== want_res.mins ||
              got_res.secs !== want_res.secs)
            note_failure(want_res, got_res, 1'b0);
        end
        if ($urandom_range(0, 149) == 0) out_burst = !out_burst;
        out_wait = out_burst ? 0 : $urandom_range(0, 7);
      end else if (out_wait != 0) begin
        out_wait--;
      end
      out_stall <= (out_wait != 0);
    end
  end

  // --------------------------------------------------------------------------
  // watchdog: cycles in a row with no word moving on either side
  // --------------------------------------------------------------------------
  int unsigned idle_cycles = 0;

  always @(posedge clk) begin
    if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= IDLE_LIMIT) begin
      $display("%0t: no word accepted for %0d cycles", $realtime, IDLE_LIMIT);
      $display("** deadline_timer_table_core: FAILED **");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

endmodule
